// ===== hdl/vcim_pkg.sv =====
`timescale 1ns / 1ps

package vcim_pkg;

  // Grid geometry and field widths.
  localparam int MAX_DIM       = 32;
  localparam int CODE_BITS     = 5;
  localparam int COORD_BITS    = 5;
  localparam int SIZE_BITS     = 6;
  localparam int CMP_BITS      = SIZE_BITS + 1;
  localparam int ADDR_BITS     = 3 * COORD_BITS;
  localparam int DEPTH         = 1 << ADDR_BITS;
  localparam int PAIR_BITS     = 2 * CODE_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(20);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Y = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Z = CFG_IDX_BITS'(2);

  // Input item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CODE_BITS-1:0]  code_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [CMP_BITS-1:0]   extent_t;

  // Operation classified by the front end.
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_OOB
  } op_e;

  typedef struct packed {
    extent_t x;
    extent_t y;
    extent_t z;
  } ext_t;

  typedef struct packed {
    op_e    op;
    coord_t x;
    coord_t y;
    coord_t z;
    code_t  first;
    code_t  second;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_Y,
    ST_RD_Z,
    ST_RD_C,
    ST_RESULT
  } state_e;

  // Extent in use: the register value limited to the grid dimension.
  function automatic extent_t extent(input logic [SIZE_BITS-1:0] size);
    extent_t s;
    s = CMP_BITS'(size);
    if (s > CMP_BITS'(MAX_DIM)) begin
      return CMP_BITS'(MAX_DIM);
    end
    return s;
  endfunction

  function automatic logic coord_in(input coord_t c, input extent_t e);
    return CMP_BITS'(c) < e;
  endfunction

  // True when c + 1 still lies inside the extent.
  function automatic logic plus_ok(input coord_t c, input extent_t e);
    return (CMP_BITS'(c) + CMP_BITS'(1)) < e;
  endfunction

  function automatic addr_t addr_of(input coord_t x, input coord_t y, input coord_t z);
    return {x, y, z};
  endfunction

endpackage

// ===== hdl/vcim_if.sv =====
`timescale 1ns / 1ps

// Input channel: one beat is a write or a query.
interface vcim_in_if;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  vcim_pkg::coord_t      x;
  vcim_pkg::coord_t      y;
  vcim_pkg::coord_t      z;
  vcim_pkg::code_t       first_value;
  vcim_pkg::code_t       second_value;

  modport source (
    output valid, kind, x, y, z, first_value, second_value,
    input  ready
  );
  modport sink (
    input  valid, kind, x, y, z, first_value, second_value,
    output ready
  );
endinterface

// Output channel: one beat per query.
interface vcim_out_if;
  logic             valid;
  logic             ready;
  vcim_pkg::code_t  first_masked;
  vcim_pkg::code_t  second_masked;
  logic             out_of_range;

  modport source (
    output valid, first_masked, second_masked, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, first_masked, second_masked, out_of_range,
    output ready
  );
endinterface

// ===== hdl/voxel_contact_interface_mask.sv =====
`timescale 1ns / 1ps

// Channel    Dir   Beat
// in_if      in    kind, x, y, z, first_value, second_value
// out_if     out   first_masked, second_masked, out_of_range (one per query)
// cfg        in    cfg_we_i, cfg_idx_i, cfg_wdata_i (size_x, size_y, size_z)
//
// A query makes seven voxel reads in the back end over the two read ports of
// the voxel memory. After reset the memory is cleared one voxel per cycle:
// in_if.ready stays low for the whole clearing pass.
// A four-entry queue separates the front end from the back end, and an output
// register lets the next item enter while a result waits on out_if.ready.

module voxel_contact_interface_mask (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  vcim_in_if.sink                               in_if,
  vcim_out_if.source                            out_if,
  input  logic                                  cfg_we_i,
  input  logic [vcim_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [vcim_pkg::SIZE_BITS-1:0]        cfg_wdata_i
);

  logic [vcim_pkg::SIZE_BITS-1:0] size_x_q, size_y_q, size_z_q;
  vcim_pkg::ext_t                 ext;
  logic                           clearing;
  logic                           full;
  logic                           push;
  vcim_pkg::cmd_t                 push_cmd;
  logic                           q_valid;
  logic                           q_pop;
  vcim_pkg::cmd_t                 q_head;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= vcim_pkg::SIZE_RESET;
      size_y_q <= vcim_pkg::SIZE_RESET;
      size_z_q <= vcim_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vcim_pkg::REG_SIZE_X: size_x_q <= cfg_wdata_i;
        vcim_pkg::REG_SIZE_Y: size_y_q <= cfg_wdata_i;
        vcim_pkg::REG_SIZE_Z: size_z_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Extent in use along each axis.
  assign ext.x = vcim_pkg::extent(size_x_q);
  assign ext.y = vcim_pkg::extent(size_y_q);
  assign ext.z = vcim_pkg::extent(size_z_q);

  vcim_front u_front (
    .ext_i      (ext),
    .clearing_i (clearing),
    .full_i     (full),
    .in_if      (in_if),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  vcim_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  vcim_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ext_i      (ext),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_head),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .out_if     (out_if)
  );

endmodule

// ===== hdl/vcim_front.sv =====
`timescale 1ns / 1ps

module vcim_front (
  input  vcim_pkg::ext_t  ext_i,
  input  logic            clearing_i,
  input  logic            full_i,
  vcim_in_if.sink         in_if,
  output logic            push_o,
  output vcim_pkg::cmd_t  cmd_o
);

  logic in_ext;

  // Range check of the beat's coordinate against the extent in use.
  assign in_ext = vcim_pkg::coord_in(in_if.x, ext_i.x) &&
                  vcim_pkg::coord_in(in_if.y, ext_i.y) &&
                  vcim_pkg::coord_in(in_if.z, ext_i.z);

  assign in_if.ready = !clearing_i && !full_i;

  // Classify the beat; a write outside the extent is dropped here.
  always_comb begin
    cmd_o.x      = in_if.x;
    cmd_o.y      = in_if.y;
    cmd_o.z      = in_if.z;
    cmd_o.first  = in_if.first_value;
    cmd_o.second = in_if.second_value;
    if (in_if.kind == vcim_pkg::KIND_WRITE) begin
      cmd_o.op = vcim_pkg::OP_WRITE;
    end else if (in_ext) begin
      cmd_o.op = vcim_pkg::OP_QUERY;
    end else begin
      cmd_o.op = vcim_pkg::OP_OOB;
    end
    push_o = in_if.valid && in_if.ready &&
             !((in_if.kind == vcim_pkg::KIND_WRITE) && !in_ext);
  end

endmodule

// ===== hdl/vcim_fifo.sv =====
`timescale 1ns / 1ps

module vcim_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vcim_pkg::cmd_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output vcim_pkg::cmd_t  head_o
);

  localparam int CNT_BITS = vcim_pkg::FIFO_PTR_BITS + 1;

  vcim_pkg::cmd_t                     slot_q [vcim_pkg::FIFO_DEPTH];
  logic [vcim_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [vcim_pkg::FIFO_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0]                count_q, count_d;

  assign full_o  = (count_q == CNT_BITS'(vcim_pkg::FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/vcim_back.sv =====
`timescale 1ns / 1ps

module vcim_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vcim_pkg::ext_t  ext_i,
  input  logic            q_valid_i,
  input  vcim_pkg::cmd_t  q_cmd_i,
  output logic            q_pop_o,
  output logic            clearing_o,
  vcim_out_if.source      out_if
);

  localparam int CB = vcim_pkg::CODE_BITS;
  localparam int PB = vcim_pkg::PAIR_BITS;

  // Both grids share one word per voxel: grid A in the upper half.
  logic [PB-1:0] pair_mem [vcim_pkg::DEPTH];

  vcim_pkg::state_e state_q, state_d;
  vcim_pkg::addr_t  clr_q, clr_d;
  vcim_pkg::cmd_t   cur_q, cur_d;
  vcim_pkg::code_t  acc_a_q, acc_a_d;
  vcim_pkg::code_t  acc_b_q, acc_b_d;
  logic [PB-1:0]    rd0_q, rd1_q;
  logic [1:0]       rd_ok_q, rd_ok_d;

  logic             wr_en;
  vcim_pkg::addr_t  wr_addr;
  logic [PB-1:0]    wr_data;
  logic             rd_en;
  vcim_pkg::addr_t  rd_addr0, rd_addr1;

  logic             dispatch;
  logic             out_free;
  logic             out_load;
  logic             load_oob;
  vcim_pkg::code_t  nbr_a, nbr_b;

  logic             out_valid_q;
  vcim_pkg::code_t  out_first_q, out_second_q;
  logic             out_oob_q;

  assign clearing_o = (state_q == vcim_pkg::ST_CLEAR);
  assign out_free   = !out_valid_q || out_if.ready;

  // Neighbor codes of the last read pair, masked where the neighbor is outside.
  assign nbr_a = (rd_ok_q[0] ? rd0_q[PB-1:CB] : '0) | (rd_ok_q[1] ? rd1_q[PB-1:CB] : '0);
  assign nbr_b = (rd_ok_q[0] ? rd0_q[CB-1:0]  : '0) | (rd_ok_q[1] ? rd1_q[CB-1:0]  : '0);

  // Sequencer: clearing pass, dispatch, neighbor reads and result.
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cur_d    = cur_q;
    acc_a_d  = acc_a_q;
    acc_b_d  = acc_b_q;
    rd_ok_d  = rd_ok_q;
    q_pop_o  = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = vcim_pkg::addr_of(q_cmd_i.x, q_cmd_i.y, q_cmd_i.z);
    wr_data  = {q_cmd_i.first, q_cmd_i.second};
    rd_en    = 1'b0;
    rd_addr0 = vcim_pkg::addr_of(cur_q.x, cur_q.y, cur_q.z);
    rd_addr1 = rd_addr0;
    dispatch = 1'b0;
    out_load = 1'b0;
    load_oob = 1'b0;

    case (state_q)
      vcim_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == {vcim_pkg::ADDR_BITS{1'b1}}) begin
          state_d = vcim_pkg::ST_IDLE;
        end
      end
      vcim_pkg::ST_IDLE: begin
        dispatch = 1'b1;
      end
      vcim_pkg::ST_RD_Y: begin
        rd_en    = 1'b1;
        rd_addr0 = vcim_pkg::addr_of(cur_q.x, vcim_pkg::COORD_BITS'(cur_q.y - 1'b1), cur_q.z);
        rd_addr1 = vcim_pkg::addr_of(cur_q.x, vcim_pkg::COORD_BITS'(cur_q.y + 1'b1), cur_q.z);
        rd_ok_d  = {vcim_pkg::plus_ok(cur_q.y, ext_i.y), cur_q.y != '0};
        acc_a_d  = nbr_a;
        acc_b_d  = nbr_b;
        state_d  = vcim_pkg::ST_RD_Z;
      end
      vcim_pkg::ST_RD_Z: begin
        rd_en    = 1'b1;
        rd_addr0 = vcim_pkg::addr_of(cur_q.x, cur_q.y, vcim_pkg::COORD_BITS'(cur_q.z - 1'b1));
        rd_addr1 = vcim_pkg::addr_of(cur_q.x, cur_q.y, vcim_pkg::COORD_BITS'(cur_q.z + 1'b1));
        rd_ok_d  = {vcim_pkg::plus_ok(cur_q.z, ext_i.z), cur_q.z != '0};
        acc_a_d  = acc_a_q | nbr_a;
        acc_b_d  = acc_b_q | nbr_b;
        state_d  = vcim_pkg::ST_RD_C;
      end
      vcim_pkg::ST_RD_C: begin
        // Center voxel on port 0; port 1 reads the same address and is masked off.
        rd_en    = 1'b1;
        rd_ok_d  = 2'b01;
        acc_a_d  = acc_a_q | nbr_a;
        acc_b_d  = acc_b_q | nbr_b;
        state_d  = vcim_pkg::ST_RESULT;
      end
      vcim_pkg::ST_RESULT: begin
        if (out_free) begin
          out_load = 1'b1;
          dispatch = 1'b1;
          state_d  = vcim_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vcim_pkg::ST_CLEAR;
      end
    endcase

    // Take the next queued command.
    if (dispatch && q_valid_i) begin
      case (q_cmd_i.op)
        vcim_pkg::OP_WRITE: begin
          q_pop_o = 1'b1;
          wr_en   = 1'b1;
        end
        vcim_pkg::OP_QUERY: begin
          q_pop_o  = 1'b1;
          cur_d    = q_cmd_i;
          rd_en    = 1'b1;
          rd_addr0 = vcim_pkg::addr_of(vcim_pkg::COORD_BITS'(q_cmd_i.x - 1'b1),
                                       q_cmd_i.y, q_cmd_i.z);
          rd_addr1 = vcim_pkg::addr_of(vcim_pkg::COORD_BITS'(q_cmd_i.x + 1'b1),
                                       q_cmd_i.y, q_cmd_i.z);
          rd_ok_d  = {vcim_pkg::plus_ok(q_cmd_i.x, ext_i.x), q_cmd_i.x != '0};
          state_d  = vcim_pkg::ST_RD_Y;
        end
        vcim_pkg::OP_OOB: begin
          // Needs the output register, so only from idle.
          if (state_q == vcim_pkg::ST_IDLE && out_free) begin
            q_pop_o  = 1'b1;
            load_oob = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vcim_pkg::ST_CLEAR;
      clr_q       <= '0;
      rd_ok_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (rd_en) begin
        rd_ok_q <= rd_ok_d;
      end
      if (out_load || load_oob) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    acc_a_q <= acc_a_d;
    acc_b_q <= acc_b_d;
    if (out_load) begin
      out_first_q  <= (acc_b_q != '0) ? rd0_q[PB-1:CB] : '0;
      out_second_q <= (acc_a_q != '0) ? rd0_q[CB-1:0]  : '0;
      out_oob_q    <= 1'b0;
    end else if (load_oob) begin
      out_first_q  <= '0;
      out_second_q <= '0;
      out_oob_q    <= 1'b1;
    end
  end

  // Voxel memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pair_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd0_q <= pair_mem[rd_addr0];
      rd1_q <= pair_mem[rd_addr1];
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.first_masked  = out_first_q;
  assign out_if.second_masked = out_second_q;
  assign out_if.out_of_range  = out_oob_q;

  // No command leaves the queue during the clearing pass.
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !q_pop_o)
    else $error("command taken during clearing pass");

  // Only a present command is taken.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

  // A write never shares a cycle with a read.
  a_wr_rd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !rd_en)
    else $error("write and read in one cycle");

  // An out-of-range result carries zero codes.
  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_oob_q) |-> (out_first_q == '0 && out_second_q == '0))
    else $error("out-of-range result with nonzero code");

  // A dispatched query walks through the neighbor reads.
  a_query_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_cmd_i.op == vcim_pkg::OP_QUERY) |=> state_q == vcim_pkg::ST_RD_Y)
    else $error("query did not start reading");

endmodule

// ===== tb/vcim_tb_pkg.sv =====
`timescale 1ns / 1ps

package vcim_tb_pkg;
  import vcim_pkg::*;

  // One result beat as the checker sees it.
  typedef struct packed {
    code_t first;
    code_t second;
    logic  out_of_range;
  } masked_t;

  // Keeps a shadow copy of both voxel grids and the size registers, works out
  // the masked pair for every accepted query and checks the result beats.
  class contact_scoreboard;
    code_t                grid_a [DEPTH];
    code_t                grid_b [DEPTH];
    logic [SIZE_BITS-1:0] size_reg [3];
    masked_t              masked_q [$];
    int                   mismatches;
    int                   results_seen;

    function new();
      foreach (grid_a[i]) begin
        grid_a[i] = '0;
        grid_b[i] = '0;
      end
      foreach (size_reg[i]) size_reg[i] = SIZE_RESET;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // Extent in use along one axis: the register, capped at the grid size.
    function int extent_of(logic [SIZE_BITS-1:0] size);
      return (int'(size) > MAX_DIM) ? MAX_DIM : int'(size);
    endfunction

    function bit covers(int x, int y, int z);
      if (x < 0 || y < 0 || z < 0) return 1'b0;
      return x < extent_of(size_reg[0]) && y < extent_of(size_reg[1]) &&
             z < extent_of(size_reg[2]);
    endfunction

    // Voxels outside the extent read as empty.
    function code_t peek(bit from_b, int x, int y, int z);
      int idx;
      if (!covers(x, y, z)) return '0;
      idx = (x * MAX_DIM + y) * MAX_DIM + z;
      return from_b ? grid_b[idx] : grid_a[idx];
    endfunction

    // True when any of the six face neighbors in the chosen grid is occupied.
    function bit touches(bit from_b, int x, int y, int z);
      return (peek(from_b, x - 1, y, z) | peek(from_b, x + 1, y, z) |
              peek(from_b, x, y - 1, z) | peek(from_b, x, y + 1, z) |
              peek(from_b, x, y, z - 1) | peek(from_b, x, y, z + 1)) != '0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SIZE_BITS-1:0] val);
      case (idx)
        REG_SIZE_X: size_reg[0] = val;
        REG_SIZE_Y: size_reg[1] = val;
        REG_SIZE_Z: size_reg[2] = val;
        default: ;
      endcase
    endfunction

    // Applies a write beat to the grids or queues the result of a query beat.
    function void note_input(logic kind, coord_t x, coord_t y, coord_t z,
                             code_t first_value, code_t second_value);
      masked_t want;
      int xi, yi, zi, idx;
      xi  = int'(x);
      yi  = int'(y);
      zi  = int'(z);
      idx = (xi * MAX_DIM + yi) * MAX_DIM + zi;
      if (kind == KIND_WRITE) begin
        if (covers(xi, yi, zi)) begin
          grid_a[idx] = first_value;
          grid_b[idx] = second_value;
        end
        return;
      end
      if (!covers(xi, yi, zi)) begin
        want = '{first: '0, second: '0, out_of_range: 1'b1};
      end else begin
        want.first        = touches(1'b1, xi, yi, zi) ? grid_a[idx] : '0;
        want.second       = touches(1'b0, xi, yi, zi) ? grid_b[idx] : '0;
        want.out_of_range = 1'b0;
      end
      masked_q = {masked_q, want};
    endfunction

    function int pending();
      return masked_q.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(code_t first, code_t second, logic out_of_range);
      masked_t want;
      results_seen++;
      if (masked_q.size() == 0) begin
        report($sformatf("result %0d has no query waiting (%0d %0d %0b)",
                         results_seen, first, second, out_of_range));
        return;
      end
      want = masked_q.pop_front();
      if (first !== want.first)
        report($sformatf("result %0d first_masked %0d, wanted %0d",
                         results_seen, first, want.first));
      if (second !== want.second)
        report($sformatf("result %0d second_masked %0d, wanted %0d",
                         results_seen, second, want.second));
      if (out_of_range !== want.out_of_range)
        report($sformatf("result %0d out_of_range %0b, wanted %0b",
                         results_seen, out_of_range, want.out_of_range));
    endtask
  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import vcim_pkg::*;
  import vcim_tb_pkg::*;

  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT         = 400000;
  localparam int PHASE_ITEMS   = 125;
  localparam int PHASES        = 13;

  // Index past the register list; a write there must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = CFG_IDX_BITS'(3);

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [SIZE_BITS-1:0]    cfg_wdata_i;

  vcim_in_if  in_if ();
  vcim_out_if out_if ();

  contact_scoreboard sb;
  bit idle_en;
  bit stall_en;
  bit long_hold_pending;
  int hold_left;
  int cycles;

  voxel_contact_interface_mask DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Run limit, far above the slowest correct run including the clearing pass.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick ready for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.first_masked, out_if.second_masked, out_if.out_of_range);
      end
      if (long_hold_pending) begin
        hold_left         = LONG_HOLD;
        long_hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 6);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Code with a strong bias toward empty voxels so contacts go both ways.
  function automatic code_t random_code();
    if ($urandom_range(0, 99) < 35) return '0;
    return code_t'($urandom_range(1, 31));
  endfunction

  // Mostly small extents to keep the grid dense, sometimes full or clamped.
  function automatic logic [SIZE_BITS-1:0] pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return SIZE_BITS'($urandom_range(1, 6));
    if (r < 17) return SIZE_BITS'($urandom_range(7, 31));
    if (r < 19) return SIZE_BITS'(MAX_DIM);
    return SIZE_BITS'($urandom_range(33, 63));
  endfunction

  // Offers one beat, with an optional idle burst ahead of it, and waits for it.
  task automatic send_item(input logic kind, input coord_t x, input coord_t y,
                           input coord_t z, input code_t first_value,
                           input code_t second_value);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= kind;
    in_if.x            <= x;
    in_if.y            <= y;
    in_if.z            <= z;
    in_if.first_value  <= first_value;
    in_if.second_value <= second_value;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(kind, x, y, z, first_value, second_value);
  endtask

  // Waits for every query to be answered, then lets trailing writes settle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three sizes back to back once the block is idle, then the unused index when asked.
  task automatic reconfigure(input logic [SIZE_BITS-1:0] sx,
                             input logic [SIZE_BITS-1:0] sy,
                             input logic [SIZE_BITS-1:0] sz, input bit poke_unused);
    logic [CFG_IDX_BITS-1:0] idx [4];
    logic [SIZE_BITS-1:0]    vals [4];
    int                      last;
    idx[0]  = REG_SIZE_X;
    idx[1]  = REG_SIZE_Y;
    idx[2]  = REG_SIZE_Z;
    idx[3]  = REG_UNUSED;
    vals[0] = sx;
    vals[1] = sy;
    vals[2] = sz;
    vals[3] = SIZE_BITS'($urandom);
    last    = poke_unused ? 3 : 2;
    wait_idle();
    for (int i = 0; i <= last; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Random writes and queries packed into a small window inside the extent,
  // with a few coordinates anywhere in the field range.
  task automatic run_phase(input logic [SIZE_BITS-1:0] sx,
                           input logic [SIZE_BITS-1:0] sy,
                           input logic [SIZE_BITS-1:0] sz, input int n_items,
                           input bit hold_midway);
    int     ext [3];
    int     base [3];
    int     span [3];
    int     counted;
    coord_t c [3];
    logic   kind;
    reconfigure(sx, sy, sz, 1'b0);
    ext[0] = sb.extent_of(sx);
    ext[1] = sb.extent_of(sy);
    ext[2] = sb.extent_of(sz);
    for (int a = 0; a < 3; a++) begin
      span[a] = (ext[a] > 4) ? 4 : ext[a];
      base[a] = (ext[a] > 4) ? $urandom_range(0, ext[a] - 4) : 0;
    end
    counted = 0;
    while (counted < n_items) begin
      if (hold_midway && counted == n_items / 2) long_hold_pending = 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (span[a] > 0 && $urandom_range(0, 19) != 0)
          c[a] = coord_t'(base[a] + $urandom_range(0, span[a] - 1));
        else
          c[a] = coord_t'($urandom_range(0, 31));
      end
      kind = ($urandom_range(0, 9) < 5) ? KIND_QUERY : KIND_WRITE;
      send_item(kind, c[0], c[1], c[2], random_code(), random_code());
      // Dropped writes outside the extent do not count.
      if (kind == KIND_QUERY || sb.covers(int'(c[0]), int'(c[1]), int'(c[2])))
        counted++;
    end
  endtask

  initial begin
    sb                 = new();
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_SIZE_X;
    cfg_wdata_i        = '0;
    in_if.valid        = 1'b0;
    in_if.kind         = KIND_WRITE;
    in_if.x            = '0;
    in_if.y            = '0;
    in_if.z            = '0;
    in_if.first_value  = '0;
    in_if.second_value = '0;
    out_if.ready       = 1'b0;
    idle_en            = 1'b1;
    stall_en           = 1'b1;
    long_hold_pending  = 1'b0;
    hold_left          = 0;
    cycles             = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Contact across one face at the origin, seen from both grids.
    send_item(KIND_WRITE, 0, 0, 0, 31, 0);
    send_item(KIND_WRITE, 1, 0, 0, 0, 31);
    send_item(KIND_QUERY, 0, 0, 0, 0, 0);
    send_item(KIND_QUERY, 1, 0, 0, 31, 31);

    // Contacts at the far corner of the reset extent.
    send_item(KIND_WRITE, 19, 19, 19, 17, 10);
    send_item(KIND_WRITE, 19, 19, 18, 0, 5);
    send_item(KIND_WRITE, 19, 18, 19, 12, 0);
    send_item(KIND_QUERY, 19, 19, 19, 31, 31);
    send_item(KIND_QUERY, 19, 19, 18, 0, 0);

    // Alternating bit patterns in both grids on adjacent voxels.
    send_item(KIND_WRITE, 10, 10, 10, 5'b10101, 5'b01010);
    send_item(KIND_WRITE, 10, 10, 11, 5'b01010, 5'b10101);
    send_item(KIND_QUERY, 10, 10, 10, 5'b01010, 5'b10101);
    send_item(KIND_QUERY, 10, 10, 11, 5'b10101, 5'b01010);

    // Outside the extent on each axis: the write is dropped, queries flag.
    send_item(KIND_WRITE, 20, 0, 0, 9, 9);
    send_item(KIND_QUERY, 20, 0, 0, 0, 0);
    send_item(KIND_QUERY, 0, 20, 0, 0, 0);
    send_item(KIND_QUERY, 0, 0, 20, 0, 0);

    // Full grid, with size_x set past the grid so the cap applies.
    reconfigure(63, 32, 32, 1'b0);
    send_item(KIND_QUERY, 20, 0, 0, 0, 0);
    send_item(KIND_WRITE, 31, 31, 31, 31, 31);
    send_item(KIND_WRITE, 31, 31, 30, 31, 31);
    send_item(KIND_QUERY, 31, 31, 31, 0, 0);

    // A single-voxel extent hides the stored neighbor of the origin.
    reconfigure(1, 1, 1, 1'b0);
    send_item(KIND_QUERY, 0, 0, 0, 0, 0);
    send_item(KIND_QUERY, 1, 0, 0, 0, 0);

    // Zero size on x puts everything outside; the unused index is poked too.
    reconfigure(0, 20, 20, 1'b1);
    send_item(KIND_QUERY, 0, 0, 0, 0, 0);

    // Growing back brings the stale contact at the origin into view again.
    reconfigure(20, 20, 20, 1'b0);
    send_item(KIND_QUERY, 0, 0, 0, 0, 0);

    // Random phases; the last one runs without idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        idle_en  = 1'b0;
        stall_en = 1'b0;
      end
      if (p == 0)
        run_phase(SIZE_BITS'(MAX_DIM), SIZE_BITS'(MAX_DIM), SIZE_BITS'(MAX_DIM),
                  PHASE_ITEMS, 1'b0);
      else
        run_phase(pick_size(), pick_size(), pick_size(), PHASE_ITEMS, p == 2);
    end

    wait_idle();
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
